[src/ihwl_pkg.sv]
package ihwl_pkg;

   typedef enum logic [3:0] {
      PH_COLON = 4'd0,
      PH_COUNT = 4'd1,
      PH_ADDR  = 4'd2,
      PH_TYPE  = 4'd3,
      PH_DATA  = 4'd4,
      PH_TRAIL = 4'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_WRITE    = 2'd0,
      ST_NOCOLON  = 2'd1,
      ST_BADHEX   = 2'd2,
      ST_UNMAPPED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_ROM_ORIGIN = 2'd0,
      CSR_ROM_SIZE   = 2'd1,
      CSR_RAM_ORIGIN = 2'd2,
      CSR_RAM_SIZE   = 2'd3
   } csr_index_type;

   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes one ASCII hex digit; ok is low for any other character.
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      logic [7:0]    diff;
      d    = '{ok: 1'b0, value: 4'd0};
      diff = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         diff = c - CH_ZERO;
         d    = '{ok: 1'b1, value: diff[3:0]};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         diff = c - CH_UPPER_A + 8'd10;
         d    = '{ok: 1'b1, value: diff[3:0]};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         diff = c - CH_LOWER_A + 8'd10;
         d    = '{ok: 1'b1, value: diff[3:0]};
      end
      return d;
   endfunction

endpackage

[src/ihwl_if.sv]
interface ihwl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface ihwl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        to_ram;
   logic [14:0] word_index;
   logic [15:0] word_data;

   modport source (output valid, output status, output to_ram, output word_index,
                   output word_data, input ready);
   modport sink   (input valid, input status, input to_ram, input word_index,
                   input word_data, output ready);
endinterface

[src/intel_hex_word_loader_unit.sv]
// A word write or error is registered and appears on rsp in the cycle after the request that completes it.
// Throughput: one character per cycle; the single result register drains while the next
// request is taken, so only a stalled result with no room blocks req.ready.
// Reset (synchronous, active high) returns the parser to waiting for a colon, clears the
// halt flag and the result valid flag, and restores the window registers to their defaults.
module intel_hex_word_loader_unit (
   input  logic                 clock,
   input  logic                 reset,
   ihwl_req_if.sink             req_chan,
   ihwl_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [16:0]          csr_wdata
);

   ihwl_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]           digit_count_ff, digit_count_in;
   logic [7:0]           bytes_left_ff, bytes_left_in;
   logic [16:0]          load_address_ff, load_address_in;
   logic [15:0]          word_accum_ff, word_accum_in;
   logic                 halted_ff, halted_in;

   logic [15:0]          rom_origin_ff, ram_origin_ff;
   logic [16:0]          rom_size_ff, ram_size_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   ihwl_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_to_ram_ff, rsp_to_ram_in;
   logic [14:0]          rsp_index_ff, rsp_index_in;
   logic [15:0]          rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 produce;
   ihwl_pkg::hex_digit_type digit;
   logic [15:0]          accum_next;
   logic [16:0]          rom_off, ram_off;
   logic                 in_rom, in_ram;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign digit          = ihwl_pkg::hex_decode(req_chan.ch);
   assign accum_next     = {word_accum_ff[11:0], digit.value};

   assign rom_off = load_address_ff - {1'b0, rom_origin_ff};
   assign ram_off = load_address_ff - {1'b0, ram_origin_ff};
   assign in_rom  = (load_address_ff >= {1'b0, rom_origin_ff}) && (rom_off < rom_size_ff);
   assign in_ram  = (load_address_ff >= {1'b0, ram_origin_ff}) && (ram_off < ram_size_ff);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept && !halted_ff) begin
         unique case (phase_ff)
            ihwl_pkg::PH_COUNT: begin
               if (digit.ok && digit_count_ff != 2'd0) phase_in = ihwl_pkg::PH_ADDR;
            end
            ihwl_pkg::PH_ADDR: begin
               if (digit.ok && digit_count_ff == 2'd3) phase_in = ihwl_pkg::PH_TYPE;
            end
            ihwl_pkg::PH_TYPE: begin
               if (digit_count_ff != 2'd0) begin
                  phase_in = (bytes_left_ff != 8'd0) ? ihwl_pkg::PH_DATA : ihwl_pkg::PH_TRAIL;
               end
            end
            ihwl_pkg::PH_DATA: begin
               if (digit.ok && digit_count_ff == 2'd3 && (in_rom || in_ram) &&
                   bytes_left_ff <= 8'd2) phase_in = ihwl_pkg::PH_TRAIL;
            end
            ihwl_pkg::PH_TRAIL: begin
               if (digit_count_ff >= 2'd2) phase_in = ihwl_pkg::PH_COLON;
            end
            default: begin
               if (req_chan.ch == ihwl_pkg::CH_COLON) phase_in = ihwl_pkg::PH_COUNT;
            end
         endcase
      end
   end

   // Datapath and result.
   always_comb begin
      digit_count_in  = digit_count_ff;
      bytes_left_in   = bytes_left_ff;
      load_address_in = load_address_ff;
      word_accum_in   = word_accum_ff;
      halted_in       = halted_ff;
      produce         = 1'b0;
      rsp_status_in   = ihwl_pkg::ST_WRITE;
      rsp_to_ram_in   = 1'b0;
      rsp_index_in    = 15'd0;
      rsp_data_in     = 16'd0;
      if (accept && !halted_ff) begin
         unique case (phase_ff)
            ihwl_pkg::PH_COUNT: begin
               if (!digit.ok) begin
                  produce = 1'b1;
                  rsp_status_in = ihwl_pkg::ST_BADHEX;
               end else begin
                  bytes_left_in = {bytes_left_ff[3:0], digit.value};
                  if (digit_count_ff != 2'd0) begin
                     digit_count_in  = 2'd0;
                     load_address_in = 17'd0;
                  end else begin
                     digit_count_in = digit_count_ff + 2'd1;
                  end
               end
            end
            ihwl_pkg::PH_ADDR: begin
               if (!digit.ok) begin
                  produce = 1'b1;
                  rsp_status_in = ihwl_pkg::ST_BADHEX;
               end else begin
                  load_address_in = {load_address_ff[12:0], digit.value};
                  digit_count_in  = digit_count_ff + 2'd1;
               end
            end
            ihwl_pkg::PH_TYPE: begin
               if (digit_count_ff != 2'd0) begin
                  digit_count_in = 2'd0;
                  word_accum_in  = 16'd0;
               end else begin
                  digit_count_in = digit_count_ff + 2'd1;
               end
            end
            ihwl_pkg::PH_DATA: begin
               if (!digit.ok) begin
                  produce = 1'b1;
                  rsp_status_in = ihwl_pkg::ST_BADHEX;
               end else if (digit_count_ff != 2'd3) begin
                  word_accum_in  = accum_next;
                  digit_count_in = digit_count_ff + 2'd1;
               end else begin
                  digit_count_in = 2'd0;
                  produce        = 1'b1;
                  if (in_rom || in_ram) begin
                     rsp_to_ram_in   = !in_rom;
                     rsp_index_in    = in_rom ? rom_off[15:1] : ram_off[15:1];
                     rsp_data_in     = accum_next;
                     word_accum_in   = 16'd0;
                     load_address_in = load_address_ff + 17'd2;
                     bytes_left_in   = (bytes_left_ff >= 8'd2) ? bytes_left_ff - 8'd2 : 8'd0;
                  end else begin
                     word_accum_in = accum_next;
                     rsp_status_in = ihwl_pkg::ST_UNMAPPED;
                  end
               end
            end
            ihwl_pkg::PH_TRAIL: begin
               digit_count_in = (digit_count_ff >= 2'd2) ? 2'd0 : digit_count_ff + 2'd1;
            end
            default: begin
               if (req_chan.ch != ihwl_pkg::CH_COLON) begin
                  produce = 1'b1;
                  rsp_status_in = ihwl_pkg::ST_NOCOLON;
               end else begin
                  digit_count_in = 2'd0;
                  bytes_left_in  = 8'd0;
               end
            end
         endcase
         if (produce && rsp_status_in != ihwl_pkg::ST_WRITE) halted_in = 1'b1;
      end
   end

   assign rsp_valid_in = produce || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= ihwl_pkg::PH_COLON;
         digit_count_ff  <= 2'd0;
         bytes_left_ff   <= 8'd0;
         load_address_ff <= 17'd0;
         word_accum_ff   <= 16'd0;
         halted_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         digit_count_ff  <= digit_count_in;
         bytes_left_ff   <= bytes_left_in;
         load_address_ff <= load_address_in;
         word_accum_ff   <= word_accum_in;
         halted_ff       <= halted_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_status_ff <= rsp_status_in;
         rsp_to_ram_ff <= rsp_to_ram_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_origin_ff <= 16'd0;
         rom_size_ff   <= 17'd32768;
         ram_origin_ff <= 16'd32768;
         ram_size_ff   <= 17'd32768;
      end else if (csr_we) begin
         unique case (ihwl_pkg::csr_index_type'(csr_index))
            ihwl_pkg::CSR_ROM_ORIGIN: rom_origin_ff <= csr_wdata[15:0];
            ihwl_pkg::CSR_ROM_SIZE:   rom_size_ff   <= csr_wdata;
            ihwl_pkg::CSR_RAM_ORIGIN: ram_origin_ff <= csr_wdata[15:0];
            ihwl_pkg::CSR_RAM_SIZE:   ram_size_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.to_ram     = rsp_to_ram_ff;
   assign rsp_chan.word_index = rsp_index_ff;
   assign rsp_chan.word_data  = rsp_data_ff;

   // Once halted, the parser stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag dropped without reset");

   // An error result on the port always goes with the halt flag.
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ihwl_pkg::ST_WRITE) |-> halted_ff)
      else $error("error reported while parser still running");

   // Without an accepted request the parser state does not move.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(phase_ff) && $stable(load_address_ff) && $stable(bytes_left_ff)))
      else $error("parser state changed without a request");

   // The trailer counts at most three characters.
   a_trail_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ihwl_pkg::PH_TRAIL) |-> (digit_count_ff != 2'd3))
      else $error("trailer counter overran");

endmodule
